// File: hw/rtl/pcbn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbn_pkg
// Shared types and constants for the per-class box suppression unit.
// ----------------------------------------------------------------------------
package pcbn_pkg;

  localparam int MAX_DETS_DEF    = 64;
  localparam int MAX_CLASSES_DEF = 16;

  localparam int COORD_W   = 16;
  localparam int SCORE_W   = 16;
  localparam int CLASS_W   = 4;
  localparam int CLS_CNT_W = 5;
  localparam int BOX_W     = 4 * COORD_W;
  localparam int ENTRY_W   = BOX_W + SCORE_W + CLASS_W;
  localparam int TDATA_W   = ((ENTRY_W + 7) / 8) * 8;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IOU_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT   = 8'd1;

  localparam logic [SCORE_W-1:0]   THRESH_RESET = 16'd29491;
  localparam logic [CLS_CNT_W-1:0] CCOUNT_RESET = 5'd4;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CLS,
    ST_FIND,
    ST_EMIT,
    ST_SUPP,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic start_scan;
    logic find_scan;
    logic supp_scan;
    logic keep;
    logic next_class;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic batch_end;
    logic cls_done;
    logic scan_done;
    logic found;
    logic push_ok;
  } status_t;

endpackage

// File: hw/rtl/pcbn_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbn_ram
// Simple single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcbn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/pcbn_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbn_datapath
// Detection store, best-box search, IoU pipeline, suppression marks and
// output staging.
// ----------------------------------------------------------------------------
module pcbn_datapath #(
  parameter int MAX_DETS    = pcbn_pkg::MAX_DETS_DEF,
  parameter int MAX_CLASSES = pcbn_pkg::MAX_CLASSES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pcbn_pkg::cmd_t                    cmd,
  output pcbn_pkg::status_t                 status,
  input  logic                              cfg_valid,
  input  logic [pcbn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcbn_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  input  logic [pcbn_pkg::ENTRY_W-1:0]      in_entry,
  input  logic                              in_end,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pcbn_pkg::ENTRY_W-1:0]      out_entry,
  output logic                              out_item_valid,
  output logic                              out_last,
  output logic                              out_ovf
);

  localparam int AW    = $clog2(MAX_DETS);
  localparam int CNT_W = $clog2(MAX_DETS + 1);
  localparam int CW    = pcbn_pkg::COORD_W;
  localparam int SW    = pcbn_pkg::SCORE_W;
  localparam int KW    = pcbn_pkg::CLASS_W;
  localparam int EW    = pcbn_pkg::ENTRY_W;
  localparam int NW    = pcbn_pkg::CLS_CNT_W;
  localparam int IW    = 2 * CW + 2;
  localparam int PW    = 2 * CW + SW + 2;

  // configuration
  logic [SW-1:0] thresh;
  logic [NW-1:0] ccount;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= pcbn_pkg::THRESH_RESET;
      ccount <= pcbn_pkg::CCOUNT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        pcbn_pkg::REG_IOU_THRESHOLD: thresh <= cfg_data[SW-1:0];
        pcbn_pkg::REG_CLASS_COUNT:   ccount <= cfg_data[NW-1:0];
        default: ;
      endcase
    end
  end

  logic [NW-1:0] ncls;
  assign ncls = (ccount > NW'(MAX_CLASSES)) ? NW'(MAX_CLASSES) : ccount;

  // store
  logic [CNT_W-1:0] count;
  logic             ovf;
  logic             in_xfer;
  logic             wr_en;
  logic [AW-1:0]    raddr;
  logic [EW-1:0]    rd;

  assign in_xfer = cmd.load && in_valid;
  assign wr_en   = in_xfer && (count < CNT_W'(MAX_DETS));

  pcbn_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_DETS)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[AW-1:0]),
    .wdata (in_entry),
    .raddr (raddr),
    .rdata (rd)
  );

  // scan control
  logic [CNT_W-1:0] idx;
  logic             issue;
  logic             d1_valid;
  logic [AW-1:0]    d1_idx;
  logic [NW-1:0]    cls;

  assign issue = (cmd.find_scan || cmd.supp_scan) && (idx < count);
  assign raddr = idx[AW-1:0];

  logic [CW-1:0] rx, ry, rw, rh;
  logic [SW-1:0] rs;
  logic [KW-1:0] rk;
  assign {rk, rs, rh, rw, ry, rx} = rd;

  logic mark_rd;
  logic d1_cand;
  assign d1_cand = d1_valid && ({1'b0, rk} == cls) && !mark_rd;

  // best box of the current class
  logic          found;
  logic [EW-1:0] best;
  logic [AW-1:0] best_idx;
  logic [CW-1:0] bx, by, bw, bh;
  logic [SW-1:0] bs;
  assign {bs, bh, bw, by, bx} = best[EW-KW-1:0];

  // iou pipeline
  logic                 v1, v2, v3, v4;
  logic [AW-1:0]        i1, i2, i3, i4;
  logic [CW:0]          iw1, ih1;
  logic [CW-1:0]        ow1, oh1;
  logic [IW-1:0]        inter2, inter3, inter4;
  logic [2*CW-1:0]      areab2, areaa;
  logic [IW-1:0]        uni3;
  logic [PW-1:0]        prod4;
  logic                 nz4;
  logic                 hit;

  logic [CW:0] ax2, ay2, cx2, cy2, lo_x, hi_x, lo_y, hi_y;
  always_comb begin
    ax2  = {1'b0, bx} + {1'b0, bw};
    ay2  = {1'b0, by} + {1'b0, bh};
    cx2  = {1'b0, rx} + {1'b0, rw};
    cy2  = {1'b0, ry} + {1'b0, rh};
    lo_x = (bx > rx) ? {1'b0, bx} : {1'b0, rx};
    lo_y = (by > ry) ? {1'b0, by} : {1'b0, ry};
    hi_x = (ax2 < cx2) ? ax2 : cx2;
    hi_y = (ay2 < cy2) ? ay2 : cy2;
  end

  assign hit = v4 && nz4 && ({inter4, {SW{1'b0}}} > prod4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= d1_cand && cmd.supp_scan;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    i1     <= d1_idx;
    iw1    <= (hi_x > lo_x) ? (hi_x - lo_x) : '0;
    ih1    <= (hi_y > lo_y) ? (hi_y - lo_y) : '0;
    ow1    <= rw;
    oh1    <= rh;
    i2     <= i1;
    inter2 <= IW'(iw1) * IW'(ih1);
    areab2 <= (2*CW)'(ow1) * (2*CW)'(oh1);
    i3     <= i2;
    inter3 <= inter2;
    uni3   <= {2'b00, areaa} + {2'b00, areab2} - inter2;
    i4     <= i3;
    inter4 <= inter3;
    prod4  <= PW'(thresh) * PW'(uni3);
    nz4    <= (uni3 != '0);
  end

  // suppression marks: cleared per entry as it loads, set on keep or overlap
  logic          mark_we;
  logic [AW-1:0] mark_waddr;
  assign mark_we    = wr_en || cmd.keep || hit;
  assign mark_waddr = wr_en ? count[AW-1:0] : (cmd.keep ? best_idx : i4);

  pcbn_ram #(
    .WIDTH (1),
    .DEPTH (MAX_DETS)
  ) u_marks (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (!wr_en),
    .raddr (raddr),
    .rdata (mark_rd)
  );

  // pending kept item and output register
  logic          pend_valid;
  logic [EW-1:0] pend;
  logic          push_ok;
  assign push_ok = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      ovf        <= 1'b0;
      idx        <= '0;
      d1_valid   <= 1'b0;
      cls        <= '0;
      found      <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      d1_valid <= issue;
      if (issue) begin
        idx <= idx + CNT_W'(1);
      end
      if (in_xfer) begin
        if (wr_en) begin
          count <= count + CNT_W'(1);
        end else begin
          ovf <= 1'b1;
        end
        if (in_end) begin
          cls <= '0;
        end
      end
      if (cmd.start_scan) begin
        idx   <= '0;
        found <= 1'b0;
      end
      if (cmd.find_scan && d1_cand && (!found || rs > bs)) begin
        found <= 1'b1;
      end
      if (cmd.next_class) begin
        cls <= cls + NW'(1);
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.keep) begin
        pend_valid <= 1'b1;
        if (pend_valid) begin
          out_valid <= 1'b1;
        end
      end
      if (cmd.flush) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
        count      <= '0;
        ovf        <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    d1_idx <= idx[AW-1:0];
    if (cmd.find_scan && d1_cand && (!found || rs > bs)) begin
      best     <= rd;
      best_idx <= d1_idx;
    end
    if (cmd.keep) begin
      areaa <= (2*CW)'(bw) * (2*CW)'(bh);
      pend  <= best;
      if (pend_valid) begin
        out_entry      <= pend;
        out_item_valid <= 1'b1;
        out_last       <= 1'b0;
        out_ovf        <= ovf;
      end
    end
    if (cmd.flush) begin
      out_entry      <= pend_valid ? pend : '0;
      out_item_valid <= pend_valid;
      out_last       <= 1'b1;
      out_ovf        <= ovf;
    end
  end

  assign status.batch_end = in_xfer && in_end;
  assign status.cls_done  = (cls >= ncls);
  assign status.scan_done = (idx >= count) && !d1_valid && !v1 && !v2 && !v3 && !v4;
  assign status.found     = found;
  assign status.push_ok   = push_ok;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_DETS))
    else $error("entry count beyond capacity");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> (count == '0) && !ovf && out_valid && out_last)
    else $error("batch state not cleared after flush");

  a_keep_pushes: assert property (@(posedge clk) disable iff (rst)
    (cmd.keep && pend_valid) |=> out_valid && !out_last && out_item_valid)
    else $error("previous kept box not pushed out");

endmodule

// File: hw/rtl/pcbn_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbn_ctrl
// Sequencer for load, per-class best search, suppression and flush.
// ----------------------------------------------------------------------------
module pcbn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  pcbn_pkg::status_t status,
  output pcbn_pkg::cmd_t    cmd
);

  pcbn_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcbn_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pcbn_pkg::ST_LOAD: begin
        if (status.batch_end) state_next = pcbn_pkg::ST_CLS;
      end
      pcbn_pkg::ST_CLS: begin
        state_next = status.cls_done ? pcbn_pkg::ST_FLUSH : pcbn_pkg::ST_FIND;
      end
      pcbn_pkg::ST_FIND: begin
        if (status.scan_done) state_next = pcbn_pkg::ST_EMIT;
      end
      pcbn_pkg::ST_EMIT: begin
        if (!status.found) begin
          state_next = pcbn_pkg::ST_CLS;
        end else if (status.push_ok) begin
          state_next = pcbn_pkg::ST_SUPP;
        end
      end
      pcbn_pkg::ST_SUPP: begin
        if (status.scan_done) state_next = pcbn_pkg::ST_CLS;
      end
      pcbn_pkg::ST_FLUSH: begin
        if (status.push_ok) state_next = pcbn_pkg::ST_LOAD;
      end
      default: state_next = pcbn_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      pcbn_pkg::ST_LOAD:  cmd.load = 1'b1;
      pcbn_pkg::ST_CLS:   cmd.start_scan = !status.cls_done;
      pcbn_pkg::ST_FIND:  cmd.find_scan = 1'b1;
      pcbn_pkg::ST_EMIT: begin
        cmd.next_class = !status.found;
        cmd.keep       = status.found && status.push_ok;
        cmd.start_scan = status.found && status.push_ok;
      end
      pcbn_pkg::ST_SUPP:  cmd.supp_scan = 1'b1;
      pcbn_pkg::ST_FLUSH: cmd.flush = status.push_ok;
      default: cmd = '0;
    endcase
  end

  a_one_phase: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.find_scan, cmd.supp_scan, cmd.flush}))
    else $error("more than one phase active");

  a_flush_to_load: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> state == pcbn_pkg::ST_LOAD)
    else $error("flush did not return to load");

  a_keep_to_supp: assert property (@(posedge clk) disable iff (rst)
    cmd.keep |=> state == pcbn_pkg::ST_SUPP)
    else $error("kept box not followed by suppression");

endmodule

// File: hw/rtl/per_class_box_nms_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_class_box_nms_unit
// Greedy per-class non-maximum suppression over a stored batch.
// ----------------------------------------------------------------------------
// Loading takes one detection per cycle; tready is low from batch end until flush.
// With n stored entries each class costs a search pass over the store plus class and
// emit steps, and each kept box a further search pass plus a suppression pass.
// A kept box leaves at the next keep or at flush; both passes share one RAM read port.
// Synchronous active-high reset: store empty, registers at defaults.
module per_class_box_nms_unit #(
  parameter int MAX_DETS    = pcbn_pkg::MAX_DETS_DEF,
  parameter int MAX_CLASSES = pcbn_pkg::MAX_CLASSES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pcbn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcbn_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // box_x, box_y, box_w, box_h, score, class, zero pad
  input  logic [pcbn_pkg::TDATA_W-1:0]      s_axis_tdata,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_x, out_y, out_w, out_h, out_score, out_class, zero pad
  output logic [pcbn_pkg::TDATA_W-1:0]      m_axis_tdata,
  // item_valid, overflowed
  output logic [1:0]                        m_axis_tuser,
  output logic                              m_axis_tlast
);

  pcbn_pkg::cmd_t    cmd;
  pcbn_pkg::status_t status;
  logic [pcbn_pkg::ENTRY_W-1:0] out_entry;
  logic out_item_valid, out_ovf;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = cmd.load;

  pcbn_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  pcbn_datapath #(
    .MAX_DETS    (MAX_DETS),
    .MAX_CLASSES (MAX_CLASSES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (s_axis_tvalid),
    .in_entry       (s_axis_tdata[pcbn_pkg::ENTRY_W-1:0]),
    .in_end         (s_axis_tlast),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_entry      (out_entry),
    .out_item_valid (out_item_valid),
    .out_last       (m_axis_tlast),
    .out_ovf        (out_ovf)
  );

  assign m_axis_tdata = {{(pcbn_pkg::TDATA_W - pcbn_pkg::ENTRY_W){1'b0}}, out_entry};
  assign m_axis_tuser = {out_ovf, out_item_valid};

endmodule
